/* src/assert_macros.svh */
// Assertion macros shared by the token decode modules.
// Every module that uses them has ports named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CHECK_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* src/bpetd_pkg.sv */
// Types, constants and decode functions for the byte level token decoder.
// Used by every module of the block; depends on nothing.
package bpetd_pkg;

   // Queue between the character assembler and the result emitter.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [20:0] CP_INVALID = 21'h00FFFD;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_mapped;
      logic       run_last;
      logic       token_end;
   } rsp_payload_type;

   // One closed character, already classified.
   typedef struct packed {
      logic            hit;
      logic [7:0]      map_byte;
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
      logic            last;
   } char_entry_type;

   typedef struct packed {
      logic           valid;
      char_entry_type entry;
   } char_word_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] value;
   } lookup_type;

   // Character length from the lead byte; invalid leads count as one byte.
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      if (!b[7]) begin
         len = 3'd1;
      end else if (b[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         len = 3'd4;
      end else begin
         len = 3'd1;
      end
      return len;
   endfunction

   // Code point of a character; missing bytes are zero.
   function automatic logic [20:0] code_point(input logic [3:0][7:0] b,
                                              input logic [2:0] len);
      logic [20:0] cp;
      case (len)
         3'd2: cp = {10'd0, b[0][4:0], b[1][5:0]};
         3'd3: cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
         3'd4: cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
         default: cp = b[0][7] ? CP_INVALID : {13'd0, b[0]};
      endcase
      return cp;
   endfunction

   // Reverse byte-to-unicode map.
   function automatic lookup_type byte_lookup(input logic [20:0] cp);
      lookup_type r;
      logic [6:0] n;
      n = cp[6:0];
      r.hit   = 1'b0;
      r.value = cp[7:0];
      if ((cp >= 21'h21 && cp <= 21'h7E) || (cp >= 21'hA1 && cp <= 21'hAC) ||
          (cp >= 21'hAE && cp <= 21'hFF)) begin
         r.hit = 1'b1;
      end else if (cp >= 21'd256 && cp < 21'd324) begin
         r.hit = 1'b1;
         if (n < 7'd33) begin
            r.value = {1'b0, n};
         end else if (n < 7'd67) begin
            r.value = {1'b0, n} + 8'h5E;
         end else begin
            r.value = 8'hAD;
         end
      end
      return r;
   endfunction

endpackage

/* src/bpetd_front.sv */
// Character assembler: groups input bytes into characters and classifies them.
// Depends on bpetd_pkg and assert_macros.svh; feeds bpetd_queue.
`include "assert_macros.svh"

module bpetd_front
   import bpetd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   input  logic            q_full,
   output char_word_type   push
);

   logic [2:0][7:0] held_ff, held_in;
   logic [2:0]      len_ff, len_in;
   logic [1:0]      seen_ff, seen_in;

   logic            accept;
   logic [2:0]      cur_len;
   logic [2:0]      count;
   logic            close;
   logic [3:0][7:0] bytes;
   lookup_type      look;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Gather the open character's bytes with the new word appended.
   always_comb begin
      cur_len = (len_ff == 3'd0) ? lead_length(req_data.in_byte) : len_ff;
      count   = {1'b0, seen_ff} + 3'd1;
      close   = (count >= cur_len) || req_data.in_last || (count >= 3'd4);
      for (int p = 0; p < 3; p++) begin
         if (p < seen_ff) begin
            bytes[p] = held_ff[p];
         end else if (p == seen_ff) begin
            bytes[p] = req_data.in_byte;
         end else begin
            bytes[p] = 8'h00;
         end
      end
      bytes[3] = (seen_ff == 2'd3) ? req_data.in_byte : 8'h00;
      look     = byte_lookup(code_point(bytes, cur_len));
   end

   // Push a closed character.
   always_comb begin
      push.valid          = accept && close;
      push.entry.hit      = look.hit;
      push.entry.map_byte = look.value;
      push.entry.bytes    = bytes;
      push.entry.count    = count;
      push.entry.last     = req_data.in_last;
   end

   // Advance or drop the open character.
   always_comb begin
      held_in = held_ff;
      len_in  = len_ff;
      seen_in = seen_ff;
      if (accept) begin
         if (close) begin
            len_in  = 3'd0;
            seen_in = 2'd0;
         end else begin
            held_in[seen_ff] = req_data.in_byte;
            len_in           = cur_len;
            seen_in          = count[1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (reset) begin
         len_ff  <= 3'd0;
         seen_ff <= 2'd0;
      end else begin
         len_ff  <= len_in;
         seen_ff <= seen_in;
      end
   end

   `CHECK_CLK(a_open_consistent, (len_ff == 3'd0) == (seen_ff == 2'd0),
              "open length and byte count disagree")
   `CHECK_CLK(a_push_count, push.valid |-> (push.entry.count != 3'd0 &&
              push.entry.count <= 3'd4), "pushed character has bad byte count")

endmodule

/* src/bpetd_queue.sv */
// Short queue of classified characters between assembler and emitter.
// Depends on bpetd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpetd_queue
   import bpetd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  char_word_type push,
   output logic          full,
   output char_word_type head,
   input  logic          pop
);

   char_entry_type      entries_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   // Advance pointers and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push.valid, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `CHECK_CLK(a_no_overflow, push.valid |-> !full, "push into full queue")
   `CHECK_CLK(a_count_bound, count_ff <= QCNT_W'(QDEPTH), "queue occupancy out of range")
   `CHECK_CLK(a_ptr_gap, (count_ff == '0 || count_ff == QCNT_W'(QDEPTH)) |->
              (wr_ptr_ff == rd_ptr_ff), "pointers disagree with occupancy")

endmodule

/* src/bpetd_back.sv */
// Result emitter: turns each queued character into one or more result words.
// Depends on bpetd_pkg and assert_macros.svh; reads bpetd_queue.
`include "assert_macros.svh"

module bpetd_back
   import bpetd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  char_word_type   head,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic [1:0]      idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            emit;
   logic            run_end;

   assign emit      = head.valid && (!rsp_valid_ff || rsp_ready);
   assign run_end   = head.entry.hit || (({1'b0, idx_ff} + 3'd1) == head.entry.count);
   assign pop       = emit && run_end;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Build the next result word from the queue head.
   always_comb begin
      rsp_data_in = rsp_data_ff;
      idx_in      = idx_ff;
      if (emit) begin
         if (head.entry.hit) begin
            rsp_data_in.out_byte   = head.entry.map_byte;
            rsp_data_in.out_mapped = 1'b1;
         end else begin
            rsp_data_in.out_byte   = head.entry.bytes[idx_ff];
            rsp_data_in.out_mapped = 1'b0;
         end
         rsp_data_in.run_last  = run_end;
         rsp_data_in.token_end = run_end && head.entry.last;
         idx_in                = run_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   // Hold the output word until taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CHECK_CLK(a_idx_in_range, head.valid |-> ({1'b0, idx_ff} < head.entry.count),
              "byte index beyond character")
   `CHECK_CLK(a_idx_idle, !head.valid |-> (idx_ff == 2'd0), "byte index left over")

endmodule

/* src/byte_level_bpe_token_decode.sv */
// Byte level BPE token decoder: one UTF-8 word in per cycle while the queue has room,
// one raw byte out per cycle while rsp_ready allows. A closing word's first result passes
// the queue, then the output register. A hit gives one result; a miss gives one per byte.
// Input is taken whenever the four-entry character queue has room.
// Synchronous reset clears the open character, the queue and the output register at once.
module byte_level_bpe_token_decode
   import bpetd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   char_word_type push;
   char_word_type head;
   logic          q_full;
   logic          pop;

   bpetd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push)
   );

   bpetd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   bpetd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
